/* rtl/core/gslr_pkg.sv */
// ----------------------------------------------------------------------------
// gslr_pkg
// Shared constants for the grid-snapped line rasteriser: register indexes,
// register widths and reset values, and the item opcodes.
// ----------------------------------------------------------------------------
package gslr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 2'd2;

  localparam int unsigned CELL_SIZE_W = 8;
  localparam int unsigned CLIP_W      = 12;

  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = 8'd1;
  localparam logic [CLIP_W-1:0]      CLIP_RST      = 12'd4095;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

/* rtl/core/grid_snapped_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// grid_snapped_line_rasterizer
// Bresenham edge walker that snaps each pixel to a configurable grid cell.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): op_i selects load or step. A load
// word takes the edge end points and returns the end point's cell.
// A step word snaps the current pixel to the grid, advances one Bresenham
// step and returns the cell if it is inside the clip bounds and new.
// Output channel (out_valid_o / out_ready_i): exactly one result word per
// input word, held in an output register until taken.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 cell size, 1 clip width,
// 2 clip height; always ready. The user must write them only while the block
// is idle; the block itself does not enforce this. One remainder unit, one
// bit a cycle, x then y; a step at the edge end skips it and goes straight
// to the final state. The block takes one word at a time; it accepts the
// next word while the last result still waits, but stalls in its final cycle
// until the output register is free. Reset clears the walker state to zero
// and loads the registers with cell size 1 and both clip bounds 4095.
// ----------------------------------------------------------------------------
module grid_snapped_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gslr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gslr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [COORD_BITS-1:0]                start_x_i,
  input  logic [COORD_BITS-1:0]                start_y_i,
  input  logic [COORD_BITS-1:0]                end_x_i,
  input  logic [COORD_BITS-1:0]                end_y_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 cell_valid_o,
  output logic [COORD_BITS-1:0]                cell_x_o,
  output logic [COORD_BITS-1:0]                cell_y_o,
  output logic                                 edge_done_o
);

  localparam int unsigned CS_W  = gslr_pkg::CELL_SIZE_W;
  localparam int unsigned CNT_W = $clog2(COORD_BITS);
  localparam int unsigned ERR_W = COORD_BITS + 2;
  localparam int unsigned E2_W  = COORD_BITS + 3;
  localparam int unsigned CMP_W = (COORD_BITS > gslr_pkg::CLIP_W) ? COORD_BITS
                                                                   : gslr_pkg::CLIP_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV_X = 2'd1;
  localparam logic [1:0] S_DIV_Y = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  // config registers
  logic [CS_W-1:0]               cell_size_q;
  logic [gslr_pkg::CLIP_W-1:0]   clip_w_q, clip_h_q;

  // walker state
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic                  dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;

  // sequencer and remainder unit
  logic [1:0]            state_q, state_d;
  logic                  is_load_q, is_load_d, at_end_q, at_end_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] opr_q, opr_d;
  logic [CS_W-1:0]       rem_q, rem_d;
  logic [COORD_BITS-1:0] lx_q, lx_d, ly_q, ly_d;

  // output register
  logic                  out_valid_q, out_valid_d, cell_valid_q, cell_valid_d;
  logic [COORD_BITS-1:0] cell_x_q, cell_x_d, cell_y_q, cell_y_d;
  logic                  done_q, done_d;

  logic [CS_W-1:0]       cs_eff;
  logic [CS_W:0]         rem_sh;
  logic [CS_W-1:0]       rem_nxt;
  logic [COORD_BITS-1:0] src_x, src_y, snap_val;
  logic signed [E2_W-1:0] e2, span_x_s, span_y_s;
  logic                  adv_x, adv_y, emit, out_free, in_fire;
  logic [COORD_BITS-1:0] step_x, step_y;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign cell_valid_o = cell_valid_q;
  assign cell_x_o     = cell_x_q;
  assign cell_y_o     = cell_y_q;
  assign edge_done_o  = done_q;

  // a cell size of zero means no snapping
  assign cs_eff = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;

  // one restoring remainder step per cycle, msb first
  assign rem_sh  = {rem_q, opr_q[COORD_BITS-1]};
  assign rem_nxt = (rem_sh >= {1'b0, cs_eff}) ? CS_W'(rem_sh - {1'b0, cs_eff})
                                              : CS_W'(rem_sh);

  assign src_x    = is_load_q ? tgt_x_q : pos_x_q;
  assign src_y    = is_load_q ? tgt_y_q : pos_y_q;
  assign snap_val = ((state_q == S_DIV_X) ? src_x : src_y)
                    - {{(COORD_BITS-CS_W){1'b0}}, rem_nxt};

  // bresenham decision on the error term before this step
  assign e2       = $signed({err_q, 1'b0});
  assign span_x_s = $signed({3'b000, span_x_q});
  assign span_y_s = $signed({3'b000, span_y_q});
  assign adv_x    = e2 > -span_y_s;
  assign adv_y    = e2 < span_x_s;
  assign step_x   = dir_x_neg_q ? pos_x_q - COORD_BITS'(1) : pos_x_q + COORD_BITS'(1);
  assign step_y   = dir_y_neg_q ? pos_y_q - COORD_BITS'(1) : pos_y_q + COORD_BITS'(1);

  assign emit = (CMP_W'(lx_q) <= CMP_W'(clip_w_q)) && (CMP_W'(ly_q) <= CMP_W'(clip_h_q))
                && ((lx_q != prev_x_q) || (ly_q != prev_y_q));

  always_comb begin
    state_d      = state_q;
    is_load_d    = is_load_q;
    at_end_d     = at_end_q;
    cnt_d        = cnt_q;
    opr_d        = opr_q;
    rem_d        = rem_q;
    lx_d         = lx_q;
    ly_d         = ly_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    tgt_x_d      = tgt_x_q;
    tgt_y_d      = tgt_y_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    dir_x_neg_d  = dir_x_neg_q;
    dir_y_neg_d  = dir_y_neg_q;
    err_d        = err_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cell_valid_d = cell_valid_q;
    cell_x_d     = cell_x_q;
    cell_y_d     = cell_y_q;
    done_d       = done_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          rem_d = '0;
          if (op_i == gslr_pkg::OP_LOAD) begin
            is_load_d   = 1'b1;
            at_end_d    = 1'b0;
            pos_x_d     = start_x_i;
            pos_y_d     = start_y_i;
            tgt_x_d     = end_x_i;
            tgt_y_d     = end_y_i;
            span_x_d    = (start_x_i < end_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
            span_y_d    = (start_y_i < end_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
            dir_x_neg_d = !(start_x_i < end_x_i);
            dir_y_neg_d = !(start_y_i < end_y_i);
            err_d       = $signed({2'b00, span_x_d}) - $signed({2'b00, span_y_d});
            opr_d       = end_x_i;
            state_d     = S_DIV_X;
          end else begin
            is_load_d = 1'b0;
            at_end_d  = (pos_x_q == tgt_x_q) && (pos_y_q == tgt_y_q);
            opr_d     = pos_x_q;
            state_d   = at_end_d ? S_FIN : S_DIV_X;
          end
        end
      end
      S_DIV_X: begin
        rem_d = rem_nxt;
        opr_d = opr_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          lx_d    = snap_val;
          rem_d   = '0;
          cnt_d   = '0;
          opr_d   = src_y;
          state_d = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        rem_d = rem_nxt;
        opr_d = opr_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          ly_d    = snap_val;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          priority if (is_load_q) begin
            // end cell always goes out and becomes the last cell
            prev_x_d     = lx_q;
            prev_y_d     = ly_q;
            cell_valid_d = 1'b1;
            cell_x_d     = lx_q;
            cell_y_d     = ly_q;
            done_d       = (pos_x_q == tgt_x_q) && (pos_y_q == tgt_y_q);
          end else if (at_end_q) begin
            cell_valid_d = 1'b0;
            cell_x_d     = '0;
            cell_y_d     = '0;
            done_d       = 1'b1;
          end else begin
            err_d = err_q
                    - (adv_x ? $signed({2'b00, span_y_q}) : $signed(ERR_W'(0)))
                    + (adv_y ? $signed({2'b00, span_x_q}) : $signed(ERR_W'(0)));
            pos_x_d      = adv_x ? step_x : pos_x_q;
            pos_y_d      = adv_y ? step_y : pos_y_q;
            cell_valid_d = emit;
            cell_x_d     = emit ? lx_q : '0;
            cell_y_d     = emit ? ly_q : '0;
            done_d       = (pos_x_d == tgt_x_q) && (pos_y_d == tgt_y_q);
            if (emit) begin
              prev_x_d = lx_q;
              prev_y_d = ly_q;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      is_load_q    <= 1'b0;
      at_end_q     <= 1'b0;
      cnt_q        <= '0;
      cell_size_q  <= gslr_pkg::CELL_SIZE_RST;
      clip_w_q     <= gslr_pkg::CLIP_RST;
      clip_h_q     <= gslr_pkg::CLIP_RST;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      tgt_x_q      <= '0;
      tgt_y_q      <= '0;
      span_x_q     <= '0;
      span_y_q     <= '0;
      dir_x_neg_q  <= 1'b0;
      dir_y_neg_q  <= 1'b0;
      err_q        <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      is_load_q    <= is_load_d;
      at_end_q     <= at_end_d;
      cnt_q        <= cnt_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      tgt_x_q      <= tgt_x_d;
      tgt_y_q      <= tgt_y_d;
      span_x_q     <= span_x_d;
      span_y_q     <= span_y_d;
      dir_x_neg_q  <= dir_x_neg_d;
      dir_y_neg_q  <= dir_y_neg_d;
      err_q        <= err_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          gslr_pkg::CFG_CELL_SIZE:   cell_size_q <= cfg_data_i[CS_W-1:0];
          gslr_pkg::CFG_CLIP_WIDTH:  clip_w_q    <= cfg_data_i[gslr_pkg::CLIP_W-1:0];
          gslr_pkg::CFG_CLIP_HEIGHT: clip_h_q    <= cfg_data_i[gslr_pkg::CLIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    opr_q        <= opr_d;
    rem_q        <= rem_d;
    lx_q         <= lx_d;
    ly_q         <= ly_d;
    cell_valid_q <= cell_valid_d;
    cell_x_q     <= cell_x_d;
    cell_y_q     <= cell_y_d;
    done_q       <= done_d;
  end

  // the remainder stays below the divisor while snapping
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV_X) || (state_q == S_DIV_Y)) |-> (rem_q < cs_eff))
    else $error("remainder out of range");

  // a dropped cell reads as zero
  a_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cell_valid_o) |-> ((cell_x_o == '0) && (cell_y_o == '0)))
    else $error("dropped cell not zero");

  // a load always emits its end cell
  a_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && is_load_q && out_free) |=> (out_valid_o && cell_valid_o))
    else $error("load result without cell");

  // an accepted word keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after accept");

  // a step at the edge end skips the snapping
  a_end_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == gslr_pkg::OP_STEP) && (pos_x_q == tgt_x_q)
     && (pos_y_q == tgt_y_q)) |=> (state_q == S_FIN))
    else $error("end step entered snapping");

endmodule

/* test/tb_grid_snapped_line_rasterizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_snapped_line_rasterizer
// Self-checking bench for the grid-snapped Bresenham edge walker. Load and
// step words go in through a bursty sender while the result side stalls on
// its own pattern. A behavioural walker inside the bench predicts every
// result word, and a checker compares each one field by field. Cell size and
// clip bounds are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_grid_snapped_line_rasterizer;

  localparam int unsigned CB = 12;
  localparam logic [CB-1:0] COORD_MAX = '1;
  localparam logic [gslr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * CB + 16;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] start_x;
    logic [CB-1:0] start_y;
    logic [CB-1:0] end_x;
    logic [CB-1:0] end_y;
  } edge_word_t;

  typedef struct packed {
    logic          cell_valid;
    logic [CB-1:0] cell_x;
    logic [CB-1:0] cell_y;
    logic          edge_done;
  } cell_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [gslr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [gslr_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 op_i;
  logic [CB-1:0]        start_x_i;
  logic [CB-1:0]        start_y_i;
  logic [CB-1:0]        end_x_i;
  logic [CB-1:0]        end_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 cell_valid_o;
  logic [CB-1:0]        cell_x_o;
  logic [CB-1:0]        cell_y_o;
  logic                 edge_done_o;

  grid_snapped_line_rasterizer #(
    .COORD_BITS(CB)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_valid_o(cell_valid_o),
    .cell_x_o    (cell_x_o),
    .cell_y_o    (cell_y_o),
    .edge_done_o (edge_done_o)
  );

  // walker state and registers as the bench sees them
  logic [gslr_pkg::CELL_SIZE_W-1:0] grid_size = gslr_pkg::CELL_SIZE_RST;
  logic [gslr_pkg::CLIP_W-1:0]      clip_w = gslr_pkg::CLIP_RST;
  logic [gslr_pkg::CLIP_W-1:0]      clip_h = gslr_pkg::CLIP_RST;
  logic [CB-1:0] walk_x = '0;
  logic [CB-1:0] walk_y = '0;
  logic [CB-1:0] goal_x = '0;
  logic [CB-1:0] goal_y = '0;
  logic [CB-1:0] run_x = '0;
  logic [CB-1:0] run_y = '0;
  logic          back_x = 1'b0;
  logic          back_y = 1'b0;
  int            bres_err = 0;
  logic [CB-1:0] last_cell_x = '0;
  logic [CB-1:0] last_cell_y = '0;

  cell_word_t expected_cells[$];
  int mismatches = 0;
  int words_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_request = 0;
  int stuck_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [CB-1:0] snap_to_grid(logic [CB-1:0] v);
    int unsigned g = (grid_size == 0) ? 1 : grid_size;
    return CB'(v - (v % g));
  endfunction

  function automatic cell_word_t predict_cell(edge_word_t w);
    cell_word_t r;
    logic [CB-1:0] lx, ly;
    int e2;
    bit emit;
    r = '0;
    if (w.op == gslr_pkg::OP_LOAD) begin
      walk_x = w.start_x;
      walk_y = w.start_y;
      goal_x = w.end_x;
      goal_y = w.end_y;
      run_x = (w.start_x < w.end_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
      run_y = (w.start_y < w.end_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
      back_x = !(w.start_x < w.end_x);
      back_y = !(w.start_y < w.end_y);
      bres_err = int'(run_x) - int'(run_y);
      last_cell_x = snap_to_grid(w.end_x);
      last_cell_y = snap_to_grid(w.end_y);
      r.cell_valid = 1'b1;
      r.cell_x = last_cell_x;
      r.cell_y = last_cell_y;
      r.edge_done = (w.start_x == w.end_x) && (w.start_y == w.end_y);
    end else if (walk_x == goal_x && walk_y == goal_y) begin
      // parked at the end point: nothing moves
      r.edge_done = 1'b1;
    end else begin
      lx = snap_to_grid(walk_x);
      ly = snap_to_grid(walk_y);
      e2 = bres_err * 2;
      if (e2 > -int'(run_y)) begin
        bres_err -= int'(run_y);
        walk_x = back_x ? walk_x - 1'b1 : walk_x + 1'b1;
      end
      if (e2 < int'(run_x)) begin
        bres_err += int'(run_x);
        walk_y = back_y ? walk_y - 1'b1 : walk_y + 1'b1;
      end
      emit = (lx <= clip_w) && (ly <= clip_h) &&
             (lx != last_cell_x || ly != last_cell_y);
      if (emit) begin
        last_cell_x = lx;
        last_cell_y = ly;
        r.cell_valid = 1'b1;
        r.cell_x = lx;
        r.cell_y = ly;
      end
      r.edge_done = (walk_x == goal_x) && (walk_y == goal_y);
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return v[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] rand_coord();
    return CB'($urandom_range(0, COORD_MAX));
  endfunction

  // step words carry junk in the coordinate fields
  function automatic edge_word_t step_word();
    return '{op: gslr_pkg::OP_STEP,
             start_x: rand_coord(), start_y: rand_coord(),
             end_x: rand_coord(), end_y: rand_coord()};
  endfunction

  task automatic send_word(input edge_word_t w);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    op_i       <= w.op;
    start_x_i  <= w.start_x;
    start_y_i  <= w.start_y;
    end_x_i    <= w.end_x;
    end_y_i    <= w.end_y;
    do @(posedge clk_i); while (!in_ready_o);
    expected_cells = {expected_cells, predict_cell(w)};
    if (burst_left > 0) burst_left--;
    words_sent++;
  endtask

  task automatic in_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  // only called with the input side idle
  task automatic write_reg(input logic [gslr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gslr_pkg::CFG_DATA_W-1:0] data);
    while (expected_cells.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      gslr_pkg::CFG_CELL_SIZE:   grid_size = data[gslr_pkg::CELL_SIZE_W-1:0];
      gslr_pkg::CFG_CLIP_WIDTH:  clip_w = data[gslr_pkg::CLIP_W-1:0];
      gslr_pkg::CFG_CLIP_HEIGHT: clip_h = data[gslr_pkg::CLIP_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [gslr_pkg::CELL_SIZE_W-1:0] cs,
                           input logic [gslr_pkg::CLIP_W-1:0] cw,
                           input logic [gslr_pkg::CLIP_W-1:0] ch);
    logic [gslr_pkg::CFG_DATA_W-gslr_pkg::CELL_SIZE_W-1:0] junk;
    junk = (gslr_pkg::CFG_DATA_W-gslr_pkg::CELL_SIZE_W)'($urandom_range(0, 15));
    in_idle();
    write_reg(gslr_pkg::CFG_CELL_SIZE, {junk, cs});
    write_reg(gslr_pkg::CFG_CLIP_WIDTH, cw);
    write_reg(gslr_pkg::CFG_CLIP_HEIGHT, ch);
  endtask

  task automatic walk_edge(input logic [CB-1:0] sx, sy, ex, ey, input int steps);
    send_word('{op: gslr_pkg::OP_LOAD, start_x: sx, start_y: sy, end_x: ex, end_y: ey});
    repeat (steps) send_word(step_word());
  endtask

  task automatic random_walk(input bit cut_short);
    logic [CB-1:0] sx, sy, ex, ey;
    int g, reach, span, dx, dy;
    g = (grid_size == 0) ? 1 : grid_size;
    case ($urandom_range(0, 3))
      0: begin
        sx = rand_coord();
        sy = rand_coord();
      end
      1: begin
        // around the clip bounds
        sx = clamp_coord(int'(clip_w) + int'($urandom_range(0, 6 * g)) - 3 * g);
        sy = clamp_coord(int'(clip_h) + int'($urandom_range(0, 6 * g)) - 3 * g);
      end
      2: begin
        sx = clamp_coord(int'($urandom_range(0, 3 * g)));
        sy = clamp_coord(int'($urandom_range(0, 3 * g)));
      end
      default: begin
        sx = clamp_coord(int'(COORD_MAX) - int'($urandom_range(0, 3 * g)));
        sy = clamp_coord(int'(COORD_MAX) - int'($urandom_range(0, 3 * g)));
      end
    endcase
    reach = ($urandom_range(0, 9) == 0) ? 40 : 10;
    ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * reach)) - reach);
    ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * reach)) - reach);
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    span = (dx > dy) ? dx : dy;
    walk_edge(sx, sy, ex, ey,
              cut_short ? int'($urandom_range(0, span)) : span + int'($urandom_range(0, 2)));
  endtask

  task automatic run_walks(input int quota);
    int stop_at, pick;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_walk(1'b0);
      end else if (pick < 90) begin
        random_walk(1'b1);
      end else begin
        send_word('{op: 1'($urandom_range(0, 1)),
                    start_x: rand_coord(), start_y: rand_coord(),
                    end_x: rand_coord(), end_y: rand_coord()});
      end
    end
  endtask

  task automatic test_reset_state();
    // steps before any load behave as steps at the edge end
    send_word('{op: gslr_pkg::OP_STEP, start_x: '0, start_y: '0, end_x: '0, end_y: '0});
    send_word('{op: gslr_pkg::OP_STEP, start_x: COORD_MAX, start_y: COORD_MAX,
                end_x: COORD_MAX, end_y: COORD_MAX});
  endtask

  task automatic test_directed_edges();
    walk_edge('0, '0, COORD_MAX, COORD_MAX, 2);
    walk_edge(COORD_MAX, COORD_MAX, '0, '0, 2);
    walk_edge(12'd7, 12'd7, 12'd7, 12'd7, 1);
    walk_edge(12'd10, 12'd5, 12'd13, 12'd5, 4);
    walk_edge(12'd3, 12'd10, 12'd4, 12'd7, 4);
  endtask

  task automatic test_grid_and_clip();
    // repeated cells and cells past the right clip bound
    configure(8'd4, 12'd3, gslr_pkg::CLIP_RST);
    write_reg(CFG_UNUSED,
              gslr_pkg::CFG_DATA_W'($urandom_range(0, (1 << gslr_pkg::CFG_DATA_W) - 1)));
    walk_edge(12'd2, 12'd1, 12'd6, 12'd2, 4);
  endtask

  task automatic test_random_walks();
    configure(gslr_pkg::CELL_SIZE_RST, gslr_pkg::CLIP_RST, gslr_pkg::CLIP_RST);
    run_walks(80);
    configure(8'd0, rand_coord(), rand_coord());
    run_walks(80);
    configure(8'd255, gslr_pkg::CLIP_RST, gslr_pkg::CLIP_RST);
    run_walks(80);
    configure(gslr_pkg::CELL_SIZE_W'($urandom_range(2, 16)), rand_coord(), rand_coord());
    run_walks(80);
    configure(gslr_pkg::CELL_SIZE_W'($urandom_range(1, 255)), '0, '0);
    run_walks(80);
    configure(8'd8, gslr_pkg::CLIP_RST, rand_coord());
    gaps_on = 1'b0;
    run_walks(80);
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(gslr_pkg::CELL_SIZE_W'($urandom_range(1, 8)), gslr_pkg::CLIP_RST,
              gslr_pkg::CLIP_RST);
    gaps_on = 1'b0;
    hold_request = 250;
    run_walks(40);
    gaps_on = 1'b1;
  endtask

  // result side: long hold-offs on request, otherwise ready streaks and short stalls
  initial begin
    int streak;
    int hold_left;
    bit take;
    streak = 0;
    hold_left = 0;
    take = 1'b1;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (streak == 0) begin
          take = ($urandom_range(0, 2) != 0);
          streak = take ? $urandom_range(1, 30) : $urandom_range(1, 6);
        end
        streak--;
        out_ready_i <= take;
      end
    end
  end

  always @(posedge clk_i) begin : check_cells
    cell_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cells.size() == 0) begin
        $error("result word with nothing expected: cell_valid %0b cell_x %0d %s",
               cell_valid_o, cell_x_o,
               $sformatf("cell_y %0d edge_done %0b", cell_y_o, edge_done_o));
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (cell_valid_o !== want.cell_valid) begin
          $error("cell_valid: expected %0b, got %0b", want.cell_valid, cell_valid_o);
          mismatches++;
        end
        if (cell_x_o !== want.cell_x) begin
          $error("cell_x: expected %0d, got %0d", want.cell_x, cell_x_o);
          mismatches++;
        end
        if (cell_y_o !== want.cell_y) begin
          $error("cell_y: expected %0d, got %0d", want.cell_y, cell_y_o);
          mismatches++;
        end
        if (edge_done_o !== want.edge_done) begin
          $error("edge_done: expected %0b, got %0b", want.edge_done, edge_done_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("grid_snapped_line_rasterizer test failed");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    op_i        <= gslr_pkg::OP_LOAD;
    start_x_i   <= '0;
    start_y_i   <= '0;
    end_x_i     <= '0;
    end_y_i     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_edges();
    test_grid_and_clip();
    test_random_walks();
    test_backpressure();

    in_idle();
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("grid_snapped_line_rasterizer test passed");
    end else begin
      $display("grid_snapped_line_rasterizer test failed");
    end
    $finish;
  end

endmodule
